// ===== hw/rtl/ntrs_pkg.sv =====
`default_nettype none

package ntrs_pkg;

   localparam int FIELD_W   = 32;
   localparam int RADIX_W   = 5;
   localparam int CHAR_W    = 8;
   localparam int DIGIT_W   = 4;
   localparam int PC_W      = 4;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   // ascii codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   typedef logic [PC_W-1:0] pc_type;

   // microprogram addresses
   localparam pc_type PC_IDLE      = 4'd0;
   localparam pc_type PC_CHECK     = 4'd1;
   localparam pc_type PC_SIGN_TEST = 4'd2;
   localparam pc_type PC_MINUS     = 4'd3;
   localparam pc_type PC_MAG_TEST  = 4'd4;
   localparam pc_type PC_DIV_INIT  = 4'd5;
   localparam pc_type PC_DIV_STEP  = 4'd6;
   localparam pc_type PC_PUSH      = 4'd7;
   localparam pc_type PC_POP       = 4'd8;
   localparam pc_type PC_EMIT_INT  = 4'd9;
   localparam pc_type PC_FRAC_TEST = 4'd10;
   localparam pc_type PC_DOT       = 4'd11;
   localparam pc_type PC_FRAC      = 4'd12;
   localparam pc_type PC_DONE      = 4'd13;
   localparam pc_type PC_ZERO      = 4'd14;
   localparam pc_type PC_ERROR     = 4'd15;

   typedef enum logic [3:0] {
      J_NEXT,
      J_ALWAYS,
      J_NO_REQ,
      J_BAD_RADIX,
      J_NO_SIGN,
      J_MAG_ZERO,
      J_DIV_MORE,
      J_QUO_NZ,
      J_STACK_NZ,
      J_FRAC_ZERO,
      J_NOT_LAST
   } jump_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_PUSH,
      OP_POP,
      OP_FRAC_INIT,
      OP_FRAC_STEP
   } op_type;

   typedef enum logic [2:0] {
      EM_NONE,
      EM_MINUS,
      EM_ZERO,
      EM_DIGIT,
      EM_DOT,
      EM_FRAC,
      EM_ERROR
   } emit_type;

   typedef struct packed {
      jump_type jump;
      pc_type   target;
      op_type   op;
      emit_type emit;
   } ucode_type;

   typedef struct packed {
      logic no_req;
      logic bad_radix;
      logic no_sign;
      logic mag_zero;
      logic div_more;
      logic quo_nz;
      logic stack_nz;
      logic frac_zero;
      logic last;
      logic stall;
   } status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'b0, d};
      end else begin
         c = CHAR_A + {4'b0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ntrs_req_if.sv =====
`default_nettype none

interface ntrs_req_if;
   import ntrs_pkg::*;

   logic               valid;
   logic               ready;
   logic               negative;
   logic [FIELD_W-1:0] int_magnitude;
   logic [FIELD_W-1:0] fraction;

   modport source (output valid, negative, int_magnitude, fraction, input ready);
   modport sink   (input valid, negative, int_magnitude, fraction, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ntrs_rsp_if.sv =====
`default_nettype none

interface ntrs_rsp_if;
   import ntrs_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last;
   logic              error;

   modport source (output valid, char_code, last, error, input ready);
   modport sink   (input valid, char_code, last, error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ntrs_rom.sv =====
`default_nettype none

module ntrs_rom (
   input  ntrs_pkg::pc_type    pc,
   output ntrs_pkg::ucode_type uword
);
   import ntrs_pkg::*;

   always_comb begin
      case (pc)
         PC_IDLE:      uword = '{jump: J_NO_REQ,    target: PC_IDLE,
                                 op: OP_LOAD,       emit: EM_NONE};
         PC_CHECK:     uword = '{jump: J_BAD_RADIX, target: PC_ERROR,
                                 op: OP_NOP,        emit: EM_NONE};
         PC_SIGN_TEST: uword = '{jump: J_NO_SIGN,   target: PC_MAG_TEST,
                                 op: OP_NOP,        emit: EM_NONE};
         PC_MINUS:     uword = '{jump: J_NEXT,      target: PC_IDLE,
                                 op: OP_NOP,        emit: EM_MINUS};
         PC_MAG_TEST:  uword = '{jump: J_MAG_ZERO,  target: PC_ZERO,
                                 op: OP_NOP,        emit: EM_NONE};
         PC_DIV_INIT:  uword = '{jump: J_NEXT,      target: PC_IDLE,
                                 op: OP_DIV_INIT,   emit: EM_NONE};
         PC_DIV_STEP:  uword = '{jump: J_DIV_MORE,  target: PC_DIV_STEP,
                                 op: OP_DIV_STEP,   emit: EM_NONE};
         PC_PUSH:      uword = '{jump: J_QUO_NZ,    target: PC_DIV_INIT,
                                 op: OP_PUSH,       emit: EM_NONE};
         PC_POP:       uword = '{jump: J_NEXT,      target: PC_IDLE,
                                 op: OP_POP,        emit: EM_NONE};
         PC_EMIT_INT:  uword = '{jump: J_STACK_NZ,  target: PC_POP,
                                 op: OP_NOP,        emit: EM_DIGIT};
         PC_FRAC_TEST: uword = '{jump: J_FRAC_ZERO, target: PC_IDLE,
                                 op: OP_NOP,        emit: EM_NONE};
         PC_DOT:       uword = '{jump: J_NEXT,      target: PC_IDLE,
                                 op: OP_FRAC_INIT,  emit: EM_DOT};
         PC_FRAC:      uword = '{jump: J_NOT_LAST,  target: PC_FRAC,
                                 op: OP_FRAC_STEP,  emit: EM_FRAC};
         PC_DONE:      uword = '{jump: J_ALWAYS,    target: PC_IDLE,
                                 op: OP_NOP,        emit: EM_NONE};
         PC_ZERO:      uword = '{jump: J_ALWAYS,    target: PC_FRAC_TEST,
                                 op: OP_NOP,        emit: EM_ZERO};
         PC_ERROR:     uword = '{jump: J_ALWAYS,    target: PC_IDLE,
                                 op: OP_NOP,        emit: EM_ERROR};
         default:      uword = '{jump: J_ALWAYS,    target: PC_IDLE,
                                 op: OP_NOP,        emit: EM_NONE};
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ntrs_seq.sv =====
`default_nettype none

module ntrs_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  ntrs_pkg::ucode_type  uword,
   input  ntrs_pkg::status_type status,
   output ntrs_pkg::pc_type     pc
);
   import ntrs_pkg::*;

   pc_type pc_ff;
   pc_type pc_in;
   logic   taken;

   always_comb begin
      case (uword.jump)
         J_NEXT:      taken = 1'b0;
         J_ALWAYS:    taken = 1'b1;
         J_NO_REQ:    taken = status.no_req;
         J_BAD_RADIX: taken = status.bad_radix;
         J_NO_SIGN:   taken = status.no_sign;
         J_MAG_ZERO:  taken = status.mag_zero;
         J_DIV_MORE:  taken = status.div_more;
         J_QUO_NZ:    taken = status.quo_nz;
         J_STACK_NZ:  taken = status.stack_nz;
         J_FRAC_ZERO: taken = status.frac_zero;
         J_NOT_LAST:  taken = !status.last;
         default:     taken = 1'b0;
      endcase

      // a step that cannot place its character holds
      if (status.stall) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = uword.target;
      end else begin
         pc_in = pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign pc = pc_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ntrs_dp.sv =====
`default_nettype none

module ntrs_dp #(
   parameter int INT_WIDTH   = 32,
   parameter int FRAC_WIDTH  = 32,
   parameter int FRAC_DIGITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   ntrs_req_if.sink                     req_if,
   ntrs_rsp_if.source                   rsp_if,
   input  logic                         csr_wr_en,
   input  logic [ntrs_pkg::RADIX_W-1:0] csr_wr_data,
   input  ntrs_pkg::ucode_type          uword,
   output ntrs_pkg::status_type         status
);
   import ntrs_pkg::*;

   localparam int DIV_STEPS = (INT_WIDTH + 3) / 4;
   localparam int DW        = DIV_STEPS * 4;
   localparam int SPW       = $clog2(INT_WIDTH + 1);
   localparam int AW        = $clog2(INT_WIDTH);
   localparam int CNT_TOP   = (DIV_STEPS > FRAC_DIGITS) ? DIV_STEPS : FRAC_DIGITS;
   localparam int CW        = $clog2(CNT_TOP + 1);
   localparam logic [63:0] INT_MASK  =
      (INT_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << INT_WIDTH) - 64'd1);
   localparam logic [63:0] FRAC_MASK =
      (FRAC_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << FRAC_WIDTH) - 64'd1);

   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic                  neg_ff, neg_in;
   logic [DW-1:0]         mag_ff, mag_in;
   logic [FRAC_WIDTH-1:0] frac_ff, frac_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [SPW-1:0]        sp_ff, sp_in;
   logic [DIGIT_W-1:0]    rd_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;
   logic                  error_ff, error_in;

   logic [DIGIT_W-1:0]    stack_mem [INT_WIDTH];

   logic                  stall;
   logic                  fire;
   logic                  take;
   logic [63:0]           int_wide;
   logic [63:0]           frac_wide;
   logic [DW-1:0]         div_q;
   logic [DIGIT_W-1:0]    div_r;
   logic [RADIX_W-1:0]    div_t;
   logic [FRAC_WIDTH+4:0] prod;
   logic [DIGIT_W-1:0]    frac_digit;
   logic [FRAC_WIDTH-1:0] frac_next;
   logic [SPW-1:0]        sp_dec;
   logic                  frac_zero;
   logic [CHAR_W-1:0]     emit_char;
   logic                  emit_last;
   logic                  emit_error;

   assign int_wide  = {32'b0, req_if.int_magnitude} & INT_MASK;
   assign frac_wide = {32'b0, req_if.fraction} & FRAC_MASK;

   assign stall = (uword.emit != EM_NONE) && rsp_valid_ff && !rsp_if.ready;
   assign fire  = !stall;
   assign take  = (uword.op == OP_LOAD) && req_if.valid;
   assign req_if.ready = (uword.op == OP_LOAD);

   assign sp_dec    = sp_ff - SPW'(1);
   assign frac_zero = (frac_ff == '0);

   // four restoring division bits per cycle
   always_comb begin
      div_q = mag_ff;
      div_r = rem_ff;
      div_t = '0;
      for (int k = 0; k < 4; k++) begin
         div_t = {div_r, div_q[DW-1]};
         div_q = {div_q[DW-2:0], 1'b0};
         if (div_t >= radix_ff) begin
            div_r    = DIGIT_W'(div_t - radix_ff);
            div_q[0] = 1'b1;
         end else begin
            div_r = div_t[DIGIT_W-1:0];
         end
      end
   end

   // fraction times base: digit above the binary point
   assign prod       = (FRAC_WIDTH+5)'(frac_ff) * (FRAC_WIDTH+5)'(radix_ff);
   assign frac_digit = prod[FRAC_WIDTH+3:FRAC_WIDTH];
   assign frac_next  = prod[FRAC_WIDTH-1:0];

   always_comb begin
      emit_error = 1'b0;
      case (uword.emit)
         EM_MINUS: begin
            emit_char = CHAR_MINUS;
            emit_last = 1'b0;
         end
         EM_ZERO: begin
            emit_char = CHAR_ZERO;
            emit_last = frac_zero;
         end
         EM_DIGIT: begin
            emit_char = digit_char(rd_ff);
            emit_last = frac_zero && (sp_ff == '0);
         end
         EM_DOT: begin
            emit_char = CHAR_DOT;
            emit_last = 1'b0;
         end
         EM_FRAC: begin
            emit_char = digit_char(frac_digit);
            emit_last = (frac_next == '0) || (cnt_ff == CW'(FRAC_DIGITS - 1));
         end
         EM_ERROR: begin
            emit_char  = CHAR_NUL;
            emit_last  = 1'b1;
            emit_error = 1'b1;
         end
         default: begin
            emit_char = CHAR_NUL;
            emit_last = 1'b0;
         end
      endcase
   end

   always_comb begin
      radix_in     = csr_wr_en ? csr_wr_data : radix_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      frac_in      = frac_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      sp_in        = sp_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      error_in     = error_ff;

      if (fire) begin
         case (uword.op)
            OP_LOAD: begin
               if (take) begin
                  neg_in  = req_if.negative;
                  mag_in  = int_wide[DW-1:0];
                  frac_in = frac_wide[FRAC_WIDTH-1:0];
                  sp_in   = '0;
               end
            end
            OP_DIV_INIT: begin
               rem_in = '0;
               cnt_in = '0;
            end
            OP_DIV_STEP: begin
               mag_in = div_q;
               rem_in = div_r;
               cnt_in = cnt_ff + CW'(1);
            end
            OP_PUSH:      sp_in = sp_ff + SPW'(1);
            OP_POP:       sp_in = sp_dec;
            OP_FRAC_INIT: cnt_in = '0;
            OP_FRAC_STEP: begin
               frac_in = frac_next;
               cnt_in  = cnt_ff + CW'(1);
            end
            default: begin
               cnt_in = cnt_ff;
            end
         endcase
      end

      if (fire && (uword.emit != EM_NONE)) begin
         rsp_valid_in = 1'b1;
         char_in      = emit_char;
         last_in      = emit_last;
         error_in     = emit_error;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= RADIX_RESET;
         cnt_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         radix_ff     <= radix_in;
         cnt_ff       <= cnt_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      frac_ff  <= frac_in;
      rem_ff   <= rem_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      error_ff <= error_in;
   end

   // digit stack: remainders pushed low digit first, popped high digit first
   always_ff @(posedge clock) begin
      if (fire && (uword.op == OP_PUSH)) begin
         stack_mem[sp_ff[AW-1:0]] <= rem_ff;
      end
      if (fire && (uword.op == OP_POP)) begin
         rd_ff <= stack_mem[sp_dec[AW-1:0]];
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.char_code = char_ff;
   assign rsp_if.last      = last_ff;
   assign rsp_if.error     = error_ff;

   always_comb begin
      status.no_req    = !req_if.valid;
      status.bad_radix = !(radix_ff inside {[RADIX_MIN:RADIX_MAX]});
      status.no_sign   = !(neg_ff && ((mag_ff != '0) || !frac_zero));
      status.mag_zero  = (mag_ff == '0);
      status.div_more  = (cnt_ff != CW'(DIV_STEPS - 1));
      status.quo_nz    = (mag_ff != '0);
      status.stack_nz  = (sp_ff != '0);
      status.frac_zero = frac_zero;
      status.last      = emit_last;
      status.stall     = stall;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/number_to_radix_string.sv =====
// one request in, its text out one character per response, a request at a time
// the first character is registered after the request is taken: the error character on a bad
// radix, else the sign, else a zero for a zero integer part, else the top integer digit once
// every digit has been found by the shared 4-bit-per-cycle divider and pushed on the stack
// reset: synchronous, radix back to 10, sequencer idle, response slot empty
`default_nettype none

module number_to_radix_string #(
   parameter int INT_WIDTH   = 32,
   parameter int FRAC_WIDTH  = 32,
   parameter int FRAC_DIGITS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   ntrs_req_if.sink                     req_if,
   ntrs_rsp_if.source                   rsp_if,
   input  logic                         csr_wr_en,
   input  logic [ntrs_pkg::RADIX_W-1:0] csr_wr_data
);
   import ntrs_pkg::*;

   // microprogram counter, control word and datapath flags
   pc_type     pc;
   ucode_type  uword;
   status_type status;

   // step counter with conditional jumps; holds while a character waits
   ntrs_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .uword  (uword),
      .status (status),
      .pc     (pc)
   );

   // control store: sign, integer digits through divide and stack,
   // then dot and fraction digits through multiply by the base
   ntrs_rom u_rom (
      .pc    (pc),
      .uword (uword)
   );

   // radix register, divider, digit stack, fraction multiplier and the
   // registered response slot that decouples the two channels
   ntrs_dp #(
      .INT_WIDTH   (INT_WIDTH),
      .FRAC_WIDTH  (FRAC_WIDTH),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .uword       (uword),
      .status      (status)
   );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import ntrs_pkg::*;

   // conversion limits of the block as built
   localparam int FRAC_DIGITS   = 10;

   // run shape
   localparam int SEND_TARGET   = 430;        // random numbers to send
   localparam int SETTLE_CYCLES = 8;          // quiet cycles before a radix write
   localparam int HOLD_CYCLES   = 400;        // long back-pressure on the text side
   localparam int TAIL_CYCLES   = 20;         // watch for stray characters at the end
   localparam int DRAIN_LIMIT   = 20000;
   localparam int RUN_LIMIT_NS  = 20_000_000;

   typedef enum logic [1:0] {
      JOB_NUMBER,    // send one number
      JOB_RADIX,     // wait for idle, then write the radix
      JOB_DRAIN,     // pause until all text is back
      JOB_HOLD       // ask the text side for a long hold-off
   } job_kind_type;

   typedef struct packed {
      job_kind_type       kind;
      logic               negative;
      logic [FIELD_W-1:0] int_magnitude;
      logic [FIELD_W-1:0] fraction;
      logic [RADIX_W-1:0] radix;
      logic [2:0]         gap;
   } job_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
      logic              error;
   } glyph_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               csr_wr_en   = 1'b0;
   logic [RADIX_W-1:0] csr_wr_data = RADIX_RESET;

   ntrs_req_if req_bus ();
   ntrs_rsp_if rsp_bus ();

   job_type            numbers_to_send[$];
   glyph_type          expected_chars[$];
   logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;

   // handshake flags sampled at the rising edge, read by the falling-edge drivers
   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;

   // sender state
   logic        offering   = 1'b0;
   int unsigned waited     = 0;
   int unsigned hold_asked = 0;

   // receiver state
   int unsigned hold_served = 0;
   int unsigned hold_left   = 0;
   int unsigned stall_left  = 0;
   logic        steady_read = 1'b0;

   int unsigned failures = 0;

   number_to_radix_string dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // expected text
   // ---------------------------------------------------------------------------------

   function automatic logic [CHAR_W-1:0] ascii_digit(input logic [DIGIT_W-1:0] value);
      if (value < 4'd10) begin
         return CHAR_ZERO + {4'b0, value};
      end
      return CHAR_A + {4'b0, value} - 8'd10;
   endfunction

   // builds the characters one number turns into and queues them
   function automatic void predict_text(input logic               negative,
                                        input logic [FIELD_W-1:0] magnitude,
                                        input logic [FIELD_W-1:0] fraction,
                                        input logic [RADIX_W-1:0] base);
      logic [CHAR_W-1:0]          text[$];
      logic [CHAR_W-1:0]          int_digits[$];
      logic [FIELD_W-1:0]         quotient;
      logic [FIELD_W-1:0]         frac_left;
      logic [FIELD_W+RADIX_W-1:0] product;
      logic [DIGIT_W-1:0]         digit;
      glyph_type                  glyph;

      // a base outside 2..16 gives a single error character
      if (base < RADIX_MIN || base > RADIX_MAX) begin
         glyph.char_code = CHAR_NUL;
         glyph.last      = 1'b1;
         glyph.error     = 1'b1;
         expected_chars.push_back(glyph);
         return;
      end

      // sign only when something nonzero follows, so negative zero prints bare
      if (negative && (magnitude != '0 || fraction != '0)) begin
         text.push_back(CHAR_MINUS);
      end

      // integer digits, least significant found first; a zero part still gives '0'
      quotient = magnitude;
      do begin
         digit = DIGIT_W'(quotient % base);
         int_digits.push_front(ascii_digit(digit));
         quotient = quotient / base;
      end while (quotient != '0);
      foreach (int_digits[k]) begin
         text.push_back(int_digits[k]);
      end

      // fraction digits by repeated multiply, truncated, stopping once nothing is left or after FRAC_DIGITS
      frac_left = fraction;
      if (frac_left != '0) begin
         text.push_back(CHAR_DOT);
         for (int i = 0; i < FRAC_DIGITS && frac_left != '0; i++) begin
            product   = frac_left * base;
            digit     = product[FIELD_W +: DIGIT_W];
            frac_left = product[FIELD_W-1:0];
            text.push_back(ascii_digit(digit));
         end
      end

      foreach (text[k]) begin
         glyph.char_code = text[k];
         glyph.last      = (k == text.size() - 1);
         glyph.error     = 1'b0;
         expected_chars.push_back(glyph);
      end
   endfunction

   task automatic report_fault(input string what);
      failures++;
      $display("%0t: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------------------
   // work list helpers
   // ---------------------------------------------------------------------------------

   function automatic void queue_number(input logic               negative,
                                        input logic [FIELD_W-1:0] magnitude,
                                        input logic [FIELD_W-1:0] fraction,
                                        input logic [2:0]         gap);
      job_type job;
      job               = '0;
      job.kind          = JOB_NUMBER;
      job.negative      = negative;
      job.int_magnitude = magnitude;
      job.fraction      = fraction;
      job.gap           = gap;
      numbers_to_send.push_back(job);
   endfunction

   function automatic void queue_marker(input job_kind_type kind,
                                        input logic [RADIX_W-1:0] radix);
      job_type job;
      job       = '0;
      job.kind  = kind;
      job.radix = radix;
      numbers_to_send.push_back(job);
   endfunction

   // mostly short integers, with full-width and all-ones values mixed in; fractions that
   // run out early, run the full ten digits, or are absent
   function automatic void queue_random(input logic [2:0] gap);
      logic [FIELD_W-1:0] magnitude;
      logic [FIELD_W-1:0] fraction;
      case ($urandom_range(0, 5))
         0:       magnitude = '0;
         1, 2:    magnitude = $urandom_range(0, 300);
         3:       magnitude = $urandom;
         4:       magnitude = $urandom >> $urandom_range(0, 31);
         default: magnitude = 32'hFFFF_FFFF ^ $urandom_range(0, 3);
      endcase
      case ($urandom_range(0, 4))
         0:       fraction = '0;
         1:       fraction = $urandom;
         2:       fraction = $urandom & ~(32'hFFFF_FFFF >> $urandom_range(1, 8));
         3:       fraction = $urandom_range(1, 255);
         default: fraction = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0001;
      endcase
      queue_number(1'($urandom_range(0, 1)), magnitude, fraction, gap);
   endfunction

   // ---------------------------------------------------------------------------------
   // rising edge: predict on every request taken, check every character taken
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin : observe
      glyph_type want;
      req_fired <= req_bus.valid && req_bus.ready && !reset;
      rsp_fired <= rsp_bus.valid && rsp_bus.ready && !reset;
      if (reset) begin
         radix_shadow <= RADIX_RESET;
      end else begin
         // radix writes only happen while idle, so the old value is right for any request
         if (csr_wr_en) begin
            radix_shadow <= csr_wr_data;
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_text(req_bus.negative, req_bus.int_magnitude, req_bus.fraction,
                         radix_shadow);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_chars.size() == 0) begin
               report_fault($sformatf(
                  "unexpected character: expected none, got %h last %b error %b",
                  rsp_bus.char_code, rsp_bus.last, rsp_bus.error));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_bus.char_code !== want.char_code) begin
                  report_fault($sformatf("char_code: expected %h, got %h",
                                         want.char_code, rsp_bus.char_code));
               end
               if (rsp_bus.last !== want.last) begin
                  report_fault($sformatf("last: expected %b, got %b", want.last, rsp_bus.last));
               end
               if (rsp_bus.error !== want.error) begin
                  report_fault($sformatf("error: expected %b, got %b", want.error, rsp_bus.error));
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // sender, falling edge: works down the list, one request on offer at a time
   // ---------------------------------------------------------------------------------

   always @(negedge clock) begin : sender
      logic write_now;
      write_now = 1'b0;
      if (!reset) begin
         if (offering && req_fired) begin
            offering = 1'b0;
         end
         if (!offering && numbers_to_send.size() != 0) begin
            case (numbers_to_send[0].kind)
               JOB_NUMBER: begin
                  // idle for the drawn gap, then put the number on the bus
                  if (waited >= numbers_to_send[0].gap) begin
                     req_bus.negative      <= numbers_to_send[0].negative;
                     req_bus.int_magnitude <= numbers_to_send[0].int_magnitude;
                     req_bus.fraction      <= numbers_to_send[0].fraction;
                     offering = 1'b1;
                     waited   = 0;
                     void'(numbers_to_send.pop_front());
                  end else begin
                     waited++;
                  end
               end
               JOB_RADIX, JOB_DRAIN: begin
                  // all text back, then a few quiet cycles so the sequencer is surely idle
                  if (expected_chars.size() != 0) begin
                     waited = 0;
                  end else if (waited < SETTLE_CYCLES) begin
                     waited++;
                  end else begin
                     if (numbers_to_send[0].kind == JOB_RADIX) begin
                        write_now = 1'b1;
                        csr_wr_data <= numbers_to_send[0].radix;
                     end
                     waited = 0;
                     void'(numbers_to_send.pop_front());
                  end
               end
               JOB_HOLD: begin
                  // sender carries on offering while the text side stalls
                  hold_asked <= hold_asked + 1;
                  void'(numbers_to_send.pop_front());
               end
               default: begin
                  void'(numbers_to_send.pop_front());
               end
            endcase
         end
      end
      req_bus.valid <= offering;
      csr_wr_en     <= write_now;
   end

   // ---------------------------------------------------------------------------------
   // receiver, falling edge: random stall after each character, calm stretches,
   // and a long hold-off when the sender asks for one
   // ---------------------------------------------------------------------------------

   always @(negedge clock) begin : receiver
      if (!reset) begin
         if (hold_served != hold_asked && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_served++;
         end
         if (rsp_fired) begin
            if ($urandom_range(0, 31) == 0) begin
               steady_read = !steady_read;
            end
            stall_left = steady_read ? 0 : $urandom_range(0, 4);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
         end
      end
      rsp_bus.ready <= !reset && hold_left == 0 && stall_left == 0;
   end

   // ---------------------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------------------

   initial begin : stimulus
      logic [RADIX_W-1:0] corner_radix[6];
      logic [RADIX_W-1:0] base;
      int unsigned        phase_len;
      int unsigned        sent;
      int unsigned        spins;
      logic               calm;

      corner_radix[0] = RADIX_MAX;
      corner_radix[1] = RADIX_MIN;
      corner_radix[2] = 5'd0;
      corner_radix[3] = 5'd31;
      corner_radix[4] = 5'd1;
      corner_radix[5] = 5'd17;

      // directed numbers in the reset radix
      queue_number(1'b0, 32'd0,          32'd0,          3'd0);  // plain zero
      queue_number(1'b1, 32'd0,          32'd0,          3'd0);  // negative zero, no sign
      queue_number(1'b1, 32'd0,          32'h8000_0000,  3'd1);  // sign kept with zero integer
      queue_number(1'b0, 32'd0,          32'h8000_0000,  3'd0);
      queue_number(1'b0, 32'd1,          32'd0,          3'd2);
      queue_number(1'b1, 32'd1,          32'd0,          3'd0);
      queue_number(1'b0, 32'hFFFF_FFFF,  32'd0,          3'd0);  // widest integer, no dot
      queue_number(1'b1, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  3'd4);  // full ten fraction digits
      queue_number(1'b0, 32'd0,          32'h0000_0001,  3'd0);  // smallest fraction
      queue_number(1'b0, 32'd10,         32'hC000_0000,  3'd0);  // fraction ends early
      queue_number(1'b0, 32'h8000_0000,  32'h4000_0000,  3'd3);
      queue_number(1'b1, 32'h7FFF_FFFF,  32'h0000_0001,  3'd0);
      queue_number(1'b0, 32'h5555_5555,  32'hAAAA_AAAA,  3'd0);
      queue_number(1'b1, 32'hAAAA_AAAA,  32'h5555_5555,  3'd1);
      queue_number(1'b0, 32'd99,         32'h1999_999A,  3'd0);
      queue_number(1'b1, 32'd0,          32'hFFFF_FFFF,  3'd0);

      // radix phases: corners first, then random bases, mostly legal
      sent = 0;
      for (int phase = 0; sent < SEND_TARGET; phase++) begin
         if (phase < 6) begin
            base = corner_radix[phase];
         end else if ($urandom_range(0, 4) == 0) begin
            base = RADIX_W'($urandom_range(0, 31));
         end else begin
            base = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
         end
         queue_marker(JOB_RADIX, base);

         if (base == RADIX_MAX) begin
            // hex letters everywhere, and in the first phase a long hold-off while requests keep coming
            queue_number(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
            if (phase == 0) begin
               queue_marker(JOB_HOLD, '0);
            end
         end else if (base == RADIX_MIN) begin
            // the longest text there is: sign, 32 bits, dot, ten digits
            queue_number(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
         end

         if (base >= RADIX_MIN && base <= RADIX_MAX) begin
            phase_len = $urandom_range(15, 40);
         end else begin
            phase_len = $urandom_range(4, 8);
         end
         calm = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < phase_len; k++) begin
            if (k == phase_len / 2 && (phase == 0 || $urandom_range(0, 2) == 0)) begin
               queue_marker(JOB_DRAIN, '0);
            end
            queue_random(calm ? 3'd0 : 3'($urandom_range(0, 4)));
            sent++;
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // everything offered and taken
      while (numbers_to_send.size() != 0 || offering) begin
         @(posedge clock);
      end
      spins = 0;
      while (expected_chars.size() != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      // a few more cycles to catch anything extra
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0) begin
         report_fault($sformatf("%0d expected characters never arrived, first %h",
                                expected_chars.size(), expected_chars[0].char_code));
      end

      if (failures == 0) begin
         $display("number_to_radix_string verification clean");
      end else begin
         $display("number_to_radix_string verification failed");
      end
      $finish;
   end

   // hard stop if the block hangs
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("number_to_radix_string verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ntrs_pkg.sv
hw/rtl/ntrs_req_if.sv
hw/rtl/ntrs_rsp_if.sv
hw/rtl/ntrs_rom.sv
hw/rtl/ntrs_seq.sv
hw/rtl/ntrs_dp.sv
hw/rtl/number_to_radix_string.sv
sim/testbench.sv
